FILE: design/state_space_trellis_branch_defines.svh
// Assertion macros for the trellis branch block.
`ifndef STATE_SPACE_TRELLIS_BRANCH_DEFINES_SVH
`define STATE_SPACE_TRELLIS_BRANCH_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SSTB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sstb assertion failed");
// Next-cycle implication, disabled during reset.
`define SSTB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sstb assertion failed");
`else
`define SSTB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSTB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: design/sstb_pkg.sv
// Package: types, constants and GF(2) helpers for the trellis branch block.
`default_nettype none
package sstb_pkg;

  localparam int SYM_W  = 8;
  localparam int SIZE_W = 4;
  localparam int MAT_W  = 64;
  localparam int IDX_W  = 3;

  localparam int DEF_MAX_STATE_BITS  = 8;
  localparam int DEF_MAX_INPUT_BITS  = 8;
  localparam int DEF_MAX_OUTPUT_BITS = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_A       = 3'd0,
    REG_B       = 3'd1,
    REG_C       = 3'd2,
    REG_D       = 3'd3,
    REG_M       = 3'd4,
    REG_K       = 3'd5,
    REG_N       = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_SEARCH
  } state_t;

  typedef enum logic {
    KIND_FWD = 1'b0,
    KIND_BWD = 1'b1
  } kind_t;

  typedef struct packed {
    logic [SIZE_W-1:0] m;
    logic [SIZE_W-1:0] k;
    logic [SIZE_W-1:0] n;
  } dims_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) r = SIZE_W'(1);
    else if (32'(v) > maxv) r = SIZE_W'(maxv);
    else r = v;
    return r;
  endfunction

  // Row vector times matrix, matrix bit j+i*rows is row j, column i.
  function automatic logic [SYM_W-1:0] gf2_mul(input logic [SYM_W-1:0] vec,
                                               input logic [SIZE_W-1:0] rows,
                                               input logic [SIZE_W-1:0] cols,
                                               input logic [MAT_W-1:0] mat);
    logic [SYM_W-1:0] res;
    logic [6:0]       pos;
    res = '0;
    for (int i = 0; i < SYM_W; i++) begin
      for (int j = 0; j < SYM_W; j++) begin
        pos = 7'(j) + 7'(i) * 7'(rows);
        if ((4'(j) < rows) && (4'(i) < cols))
          res[i] = res[i] ^ (vec[j] & mat[pos[5:0]]);
      end
    end
    return res;
  endfunction

  function automatic logic [SYM_W-1:0] low_mask(input logic [SIZE_W-1:0] bits);
    logic [SYM_W:0] one_hot;
    one_hot = (SYM_W+1)'(1) << bits;
    return SYM_W'(one_hot - (SYM_W+1)'(1));
  endfunction

endpackage
`default_nettype wire

FILE: design/sstb_branch_unit.sv
// Shared branch evaluator: next state and codeword of one trellis branch.
`default_nettype none
module sstb_branch_unit (
  input  wire logic [sstb_pkg::SYM_W-1:0] s,
  input  wire logic [sstb_pkg::SYM_W-1:0] u,
  input  wire sstb_pkg::dims_t            dims,
  input  wire logic [sstb_pkg::MAT_W-1:0] a_mat,
  input  wire logic [sstb_pkg::MAT_W-1:0] b_mat,
  input  wire logic [sstb_pkg::MAT_W-1:0] c_mat,
  input  wire logic [sstb_pkg::MAT_W-1:0] d_mat,
  output logic      [sstb_pkg::SYM_W-1:0] nxt,
  output logic      [sstb_pkg::SYM_W-1:0] cw
);
  import sstb_pkg::*;

  always_comb begin
    nxt = gf2_mul(s, dims.m, dims.m, a_mat) ^ gf2_mul(u, dims.k, dims.m, b_mat);
    cw  = gf2_mul(s, dims.m, dims.n, c_mat) ^ gf2_mul(u, dims.k, dims.n, d_mat);
  end

endmodule
`default_nettype wire

FILE: design/state_space_trellis_branch.sv
// Top level: trellis branch queries for a GF(2) state-space convolutional code.
// Forward query: start moves control to the forward state, from which done is registered; busy for one cycle.
// Backward query: one branch per cycle through the shared evaluator, symbol-major;
//   done is registered from the hit, or from the last branch when none matches.
// Next start is taken while done is high.
// Reset: matrices clear to 0, m=2, k=1, n=2; control returns to idle.
`default_nettype none
`include "state_space_trellis_branch_defines.svh"
module state_space_trellis_branch #(
  parameter int MAX_STATE_BITS  = sstb_pkg::DEF_MAX_STATE_BITS,
  parameter int MAX_INPUT_BITS  = sstb_pkg::DEF_MAX_INPUT_BITS,
  parameter int MAX_OUTPUT_BITS = sstb_pkg::DEF_MAX_OUTPUT_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        kind,
  input  wire logic [sstb_pkg::SYM_W-1:0]  query_state,
  input  wire logic [sstb_pkg::SYM_W-1:0]  query_symbol,
  input  wire logic [sstb_pkg::SYM_W-1:0]  branch_rank,
  output logic                             done,
  output logic      [sstb_pkg::SYM_W-1:0]  other_state,
  output logic      [sstb_pkg::SYM_W-1:0]  branch_symbol,
  output logic      [sstb_pkg::SYM_W-1:0]  codeword,
  output logic                             found,
  input  wire logic                        wr_en,
  input  wire logic [sstb_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [sstb_pkg::MAT_W-1:0]  wr_data
);
  import sstb_pkg::*;

  logic [MAT_W-1:0]  a_matrix, b_matrix, c_matrix, d_matrix;
  logic [SIZE_W-1:0] state_bits, input_bits, output_bits;

  state_t            state, state_next;
  kind_t             kind_q;
  dims_t             dims_q;
  logic [SYM_W-1:0]  smask_q, umask_q;
  logic [SYM_W-1:0]  st_q, rank_q, count_q;
  logic [SYM_W-1:0]  s_q, u_q;
  logic [SYM_W-1:0]  nxt, cw;
  logic              match, hit, last_s, last_u, exhausted;
  dims_t             dims_new;
  logic [SYM_W-1:0]  smask_new, umask_new;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      a_matrix    <= '0;
      b_matrix    <= '0;
      c_matrix    <= '0;
      d_matrix    <= '0;
      state_bits  <= SIZE_W'(2);
      input_bits  <= SIZE_W'(1);
      output_bits <= SIZE_W'(2);
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_A:   a_matrix    <= wr_data;
        REG_B:   b_matrix    <= wr_data;
        REG_C:   c_matrix    <= wr_data;
        REG_D:   d_matrix    <= wr_data;
        REG_M:   state_bits  <= wr_data[SIZE_W-1:0];
        REG_K:   input_bits  <= wr_data[SIZE_W-1:0];
        REG_N:   output_bits <= wr_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dims_new.m = clamp_size(state_bits, MAX_STATE_BITS);
    dims_new.k = clamp_size(input_bits, MAX_INPUT_BITS);
    dims_new.n = clamp_size(output_bits, MAX_OUTPUT_BITS);
    smask_new  = low_mask(dims_new.m);
    umask_new  = low_mask(dims_new.k);
  end

  sstb_branch_unit u_unit (
    .s     (s_q),
    .u     (u_q),
    .dims  (dims_q),
    .a_mat (a_matrix),
    .b_mat (b_matrix),
    .c_mat (c_matrix),
    .d_mat (d_matrix),
    .nxt   (nxt),
    .cw    (cw)
  );

  // control outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    match     = (nxt == st_q);
    last_s    = (s_q == smask_q);
    last_u    = (u_q == umask_q);
    hit       = (state == ST_SEARCH) && match && (count_q == rank_q);
    exhausted = (state == ST_SEARCH) && !hit && last_s && last_u;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = (kind_t'(kind) == KIND_BWD) ? ST_SEARCH : ST_FWD;
      ST_FWD:    state_next = ST_IDLE;
      ST_SEARCH: if (hit || exhausted) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FWD) || hit || exhausted;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      kind_q  <= kind_t'(kind);
      dims_q  <= dims_new;
      smask_q <= smask_new;
      umask_q <= umask_new;
      st_q    <= query_state & smask_new;
      rank_q  <= branch_rank;
      count_q <= '0;
      if (kind_t'(kind) == KIND_FWD) begin
        s_q <= query_state & smask_new;
        u_q <= query_symbol & umask_new;
      end else begin
        s_q <= '0;
        u_q <= '0;
      end
    end else if (state == ST_FWD || hit) begin
      other_state   <= (state == ST_FWD) ? nxt : s_q;
      branch_symbol <= u_q;
      codeword      <= cw;
      found         <= 1'b1;
    end else if (exhausted) begin
      other_state   <= '0;
      branch_symbol <= '0;
      codeword      <= '0;
      found         <= 1'b0;
    end else if (state == ST_SEARCH) begin
      if (match) count_q <= count_q + SYM_W'(1);
      if (last_s) begin
        s_q <= '0;
        u_q <= u_q + SYM_W'(1);
      end else begin
        s_q <= s_q + SYM_W'(1);
      end
    end
  end

  `SSTB_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `SSTB_ASSERT_NXT(a_fwd_done, clk, rst, state == ST_FWD, done && found)
  `SSTB_ASSERT_IMP(a_miss_zero, clk, rst, done && !found, ~|{other_state, branch_symbol, codeword})
  `SSTB_ASSERT_IMP(a_fwd_found, clk, rst, done && kind_q == KIND_FWD, found)
  `SSTB_ASSERT_IMP(a_search_range, clk, rst, state == ST_SEARCH, ~|({s_q, u_q} & ~{smask_q, umask_q}))

endmodule
`default_nettype wire

FILE: verif/tb_state_space_trellis_branch.sv
// Testbench for state_space_trellis_branch: directed and random trellis queries checked against a scoreboard.
`default_nettype none
module tb_state_space_trellis_branch;
  timeunit 1ns;
  timeprecision 1ps;
  import sstb_pkg::*;

  localparam int RUN_LIMIT = 4_000_000;

  typedef struct packed {
    logic [7:0] other_state;
    logic [7:0] branch_symbol;
    logic [7:0] codeword;
    logic       found;
  } branch_t;

  class branch_oracle;
    bit [63:0] mat_a, mat_b, mat_c, mat_d;
    bit [3:0]  m_raw, k_raw, n_raw;
    branch_t   pending_branches[$];
    int        mismatches;

    function new();
      mat_a = '0;
      mat_b = '0;
      mat_c = '0;
      mat_d = '0;
      m_raw = 4'd2;
      k_raw = 4'd1;
      n_raw = 4'd2;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [63:0] data);
      case (idx)
        REG_A: mat_a = data;
        REG_B: mat_b = data;
        REG_C: mat_c = data;
        REG_D: mat_d = data;
        REG_M: m_raw = data[3:0];
        REG_K: k_raw = data[3:0];
        REG_N: n_raw = data[3:0];
        default: ;
      endcase
    endfunction

    function int eff_size(bit [3:0] raw);
      if (raw == 4'd0) return 1;
      if (raw > 4'd8) return 8;
      return int'(raw);
    endfunction

    function bit [7:0] gf2_row_times(bit [7:0] vec, int rows, int cols, bit [63:0] mat);
      bit [7:0] prod;
      prod = '0;
      for (int col = 0; col < cols; col++)
        for (int row = 0; row < rows; row++)
          prod[col] = prod[col] ^ (vec[row] & mat[row + col * rows]);
      return prod;
    endfunction

    function branch_t predict_branch(kind_t kd, bit [7:0] st, bit [7:0] sym, bit [7:0] rank);
      int       m, k, n, hits;
      bit [7:0] s_red, u_red, nxt;
      branch_t  br;
      m = eff_size(m_raw);
      k = eff_size(k_raw);
      n = eff_size(n_raw);
      s_red = 8'(int'(st) & ((1 << m) - 1));
      u_red = 8'(int'(sym) & ((1 << k) - 1));
      br = '0;
      if (kd == KIND_FWD) begin
        br.other_state = gf2_row_times(s_red, m, m, mat_a) ^ gf2_row_times(u_red, k, m, mat_b);
        br.branch_symbol = u_red;
        br.codeword = gf2_row_times(s_red, m, n, mat_c) ^ gf2_row_times(u_red, k, n, mat_d);
        br.found = 1'b1;
        return br;
      end
      hits = 0;
      for (int uu = 0; uu < (1 << k); uu++) begin
        for (int ss = 0; ss < (1 << m); ss++) begin
          nxt = gf2_row_times(8'(ss), m, m, mat_a) ^ gf2_row_times(8'(uu), k, m, mat_b);
          if (nxt == s_red) begin
            if (hits == int'(rank)) begin
              br.other_state = 8'(ss);
              br.branch_symbol = 8'(uu);
              br.codeword = gf2_row_times(8'(ss), m, n, mat_c) ^
                            gf2_row_times(8'(uu), k, n, mat_d);
              br.found = 1'b1;
              return br;
            end
            hits++;
          end
        end
      end
      return br;
    endfunction

    function void note_query(kind_t kd, bit [7:0] st, bit [7:0] sym, bit [7:0] rank);
      pending_branches.push_back(predict_branch(kd, st, sym, rank));
    endfunction

    function void check_branch(branch_t got);
      branch_t want;
      if (pending_branches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: state %0h sym %0h cw %0h found %0b",
                   got.other_state, got.branch_symbol, got.codeword, got.found);
        return;
      end
      want = pending_branches.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("branch mismatch: exp state %0h sym %0h cw %0h found %0b, got state %0h sym %0h cw %0h found %0b",
                   want.other_state, want.branch_symbol, want.codeword, want.found,
                   got.other_state, got.branch_symbol, got.codeword, got.found);
      end
    endfunction

    function int outstanding();
      return pending_branches.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  kind_t      kind;
  logic [7:0] query_state;
  logic [7:0] query_symbol;
  logic [7:0] branch_rank;
  logic       done;
  logic [7:0] other_state;
  logic [7:0] branch_symbol;
  logic [7:0] codeword;
  logic       found;
  logic       wr_en;
  reg_idx_t   wr_index;
  logic [63:0] wr_data;

  branch_oracle oracle;

  state_space_trellis_branch uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .query_state(query_state), .query_symbol(query_symbol), .branch_rank(branch_rank),
    .done(done), .other_state(other_state), .branch_symbol(branch_symbol),
    .codeword(codeword), .found(found),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("tb_state_space_trellis_branch: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done)
      oracle.check_branch({other_state, branch_symbol, codeword, found});
  end

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (oracle.outstanding() != 0 || busy);
  endtask

  task automatic send_query(kind_t kd, logic [7:0] st, logic [7:0] sym, logic [7:0] rank,
                            int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= kd;
    query_state <= st;
    query_symbol <= sym;
    branch_rank <= rank;
    do @(posedge clk); while (busy);
    oracle.note_query(kd, st, sym, rank);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    oracle.set_reg(idx, data);
  endtask

  task automatic apply_setting(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d,
                               logic [3:0] m_raw, logic [3:0] k_raw, logic [3:0] n_raw);
    logic [63:0] upper;
    drain();
    repeat (2) @(posedge clk);
    upper = {$urandom, $urandom};
    write_reg(REG_A, a);
    write_reg(REG_B, b);
    write_reg(REG_C, c);
    write_reg(REG_D, d);
    write_reg(REG_M, {upper[63:4], m_raw});
    write_reg(REG_K, {upper[59:0], k_raw});
    write_reg(REG_N, {~upper[63:4], n_raw});
    if ($urandom_range(0, 1))
      write_reg(REG_UNUSED, {$urandom, $urandom});
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [3:0] raw_size(int eff);
    if (eff == 1 && $urandom_range(0, 3) == 0) return 4'd0;
    if (eff == 8 && $urandom_range(0, 1) == 0) return 4'($urandom_range(9, 15));
    return 4'(eff);
  endfunction

  function automatic logic [63:0] random_matrix();
    logic [63:0] mat;
    mat = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: mat = '0;
      1: mat = mat & {$urandom, $urandom} & {$urandom, $urandom};
      2: mat = '1;
      default: ;
    endcase
    return mat;
  endfunction

  task automatic random_phase(int items);
    int          m_eff, k_eff, n_eff, rank_top;
    bit          burst;
    kind_t       kd;
    logic [7:0]  rank;
    m_eff = $urandom_range(1, 8);
    k_eff = $urandom_range(1, (m_eff >= 8) ? 1 : 9 - m_eff);
    n_eff = $urandom_range(1, 8);
    burst = ($urandom_range(0, 3) == 0);
    apply_setting(random_matrix(), random_matrix(), random_matrix(), random_matrix(),
                  raw_size(m_eff), raw_size(k_eff), raw_size(n_eff));
    rank_top = ((1 << k_eff) > 255) ? 255 : (1 << k_eff);
    for (int i = 0; i < items; i++) begin
      kd = $urandom_range(0, 1) ? KIND_BWD : KIND_FWD;
      case ($urandom_range(0, 9))
        0: rank = 8'd0;
        1, 2: rank = 8'($urandom_range(0, 255));
        default: rank = 8'($urandom_range(0, rank_top));
      endcase
      if ($urandom_range(0, 24) == 0)
        drain();
      send_query(kd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rank,
                 burst ? 0 : $urandom_range(0, 3));
    end
  endtask

  initial begin
    oracle = new();
    rst <= 1'b1;
    start <= 1'b0;
    kind <= KIND_FWD;
    query_state <= '0;
    query_symbol <= '0;
    branch_rank <= '0;
    wr_en <= 1'b0;
    wr_index <= REG_A;
    wr_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration: all matrices zero, every branch lands in state 0
    send_query(KIND_FWD, 8'hFF, 8'hFF, 8'h00, 0);
    send_query(KIND_BWD, 8'h00, 8'hFF, 8'h00, 1);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'h07, 0);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'h08, 2);
    send_query(KIND_BWD, 8'h01, 8'h00, 8'h00, 0);

    // sizes out of range: m=0, k=15, n=9
    apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 4'd0, 4'd15, 4'd9);
    send_query(KIND_FWD, 8'h00, 8'h00, 8'hFF, 0);
    send_query(KIND_FWD, 8'hFF, 8'hFF, 8'h00, 0);
    send_query(KIND_FWD, 8'h55, 8'hAA, 8'h00, 3);
    send_query(KIND_BWD, 8'h01, 8'h00, 8'h00, 0);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'hFF, 1);
    send_query(KIND_BWD, 8'hFF, 8'h00, 8'd200, 0);

    // largest sizes
    apply_setting({$urandom, $urandom}, {$urandom, $urandom}, '1, '1, 4'd8, 4'd8, 4'd8);
    send_query(KIND_FWD, 8'hFF, 8'hFF, 8'h00, 0);
    send_query(KIND_FWD, 8'h00, 8'h00, 8'h00, 0);
    send_query(KIND_BWD, 8'($urandom_range(0, 255)), 8'h00, 8'h00, 2);
    send_query(KIND_BWD, 8'($urandom_range(0, 255)), 8'h00, 8'hFF, 0);

    // singular A with B zero: only state 0 is reachable
    apply_setting('0, '0, {$urandom, $urandom}, {$urandom, $urandom}, 4'd8, 4'd8, 4'd8);
    send_query(KIND_BWD, 8'h5A, 8'h00, 8'h00, 0);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'hFF, 0);

    // smallest sizes
    apply_setting('1, '1, '1, '1, 4'd1, 4'd1, 4'd1);
    send_query(KIND_FWD, 8'h01, 8'h01, 8'h00, 0);
    send_query(KIND_FWD, 8'hFE, 8'h01, 8'h00, 1);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'h00, 0);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'h01, 0);
    send_query(KIND_BWD, 8'h00, 8'h00, 8'h02, 3);

    for (int p = 0; p < 16; p++)
      random_phase(52);

    drain();
    repeat (20) @(posedge clk);
    if (oracle.mismatches == 0 && oracle.outstanding() == 0)
      $display("tb_state_space_trellis_branch: done, clean");
    else
      $display("tb_state_space_trellis_branch: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
